// File: design/running_stats_quake_threshold_macros.svh
// Assertion macros shared by the running statistics threshold design.
`ifndef RUNNING_STATS_QUAKE_THRESHOLD_MACROS_SVH
`define RUNNING_STATS_QUAKE_THRESHOLD_MACROS_SVH
`ifndef SYNTHESIS
`define RSQT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsqt: same-cycle check failed");
`define RSQT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsqt: next-cycle check failed");
`else
`define RSQT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSQT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/rsqt_pkg.sv
// Shared types, constants and datapath command codes for the statistics block.
package rsqt_pkg;

    localparam int MAX_SAMPLES_DEF = 65535;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int VAL_W           = 25;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam logic [15:0] SIGMA_RESET = 16'd768;

    localparam logic [1:0] ST_TAKEN   = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_RESET   = 2'd2;

    typedef logic [4:0] t_dp_op;

    localparam t_dp_op OP_NONE     = 5'd0;
    localparam t_dp_op OP_LOAD     = 5'd1;
    localparam t_dp_op OP_CLR      = 5'd2;
    localparam t_dp_op OP_SQ       = 5'd3;
    localparam t_dp_op OP_SQRT_MAG = 5'd4;
    localparam t_dp_op OP_MAG_TAKE = 5'd5;
    localparam t_dp_op OP_MDIV     = 5'd6;
    localparam t_dp_op OP_MEAN     = 5'd7;
    localparam t_dp_op OP_PROD     = 5'd8;
    localparam t_dp_op OP_M2_UPD   = 5'd9;
    localparam t_dp_op OP_VDIV     = 5'd10;
    localparam t_dp_op OP_VAR_TAKE = 5'd11;
    localparam t_dp_op OP_VSQRT    = 5'd12;
    localparam t_dp_op OP_SD_TAKE  = 5'd13;
    localparam t_dp_op OP_TH_MUL   = 5'd14;
    localparam t_dp_op OP_TH_ADD   = 5'd15;
    localparam t_dp_op OP_PUBLISH  = 5'd16;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic is_reset;
        logic sq_last;
        logic skip;
        logic cnt_lt2;
        logic out_busy;
    } t_dp_status;

endpackage

// File: design/rsqt_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module rsqt_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root,
    output logic [33:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [31:0] r_root;
    logic [33:0] r_rem;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    assign rem_sh = {r_rem[31:0], r_rad[63:62]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[30:0], ge};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;
endmodule

// File: design/rsqt_div.sv
// Restoring divider, 64-bit dividend by 16-bit divisor, one quotient bit per cycle.
module rsqt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [15:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_d;
    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign diff   = rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[15:0] : rem_sh[15:0];
            r_q   <= {r_q[62:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// File: design/rsqt_dp.sv
// Datapath: statistics state, shared divider and square root, output register.
module rsqt_dp #(
    parameter int MAX_SAMPLES = rsqt_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = rsqt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsqt_pkg::t_dp_op     i_op,
    output rsqt_pkg::t_dp_status o_st,
    input  logic [47:0]          i_s_tdata,
    input  logic [0:0]           i_s_tuser,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [119:0]         o_m_tdata,
    output logic [1:0]           o_m_tuser
);
    import rsqt_pkg::*;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [VAL_W-1:0] sat_val(input logic [63:0] v);
        return (v > 64'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
    endfunction

    logic             r_cmd;
    logic [15:0]      r_ax, r_ay, r_az;
    logic [1:0]       r_sq_idx;
    logic [31:0]      r_sum;
    logic [VAL_W-1:0] r_mag, r_mean, r_ad, r_nm, r_sd, r_thr;
    logic             r_skip, r_up, r_upd;
    logic [49:0]      r_prod;
    logic [63:0]      r_m2, r_var;
    logic [15:0]      r_count, r_sigma;
    logic [40:0]      r_thp;
    logic [1:0]       r_stat;
    logic             r_ov;
    logic [119:0]     r_o_tdata;
    logic [1:0]       r_o_tuser;

    logic             sqrt_start, sqrt_done;
    logic [63:0]      sqrt_in;
    logic [31:0]      sqrt_root;
    logic [33:0]      sqrt_rem;
    logic [32:0]      sqrt_rnd;
    logic             div_start, div_done;
    logic [63:0]      div_in, div_q;
    logic [15:0]      div_d, div_r;

    logic [15:0]      sq_op;
    logic [31:0]      sq;
    logic             up_c;
    logic [VAL_W-1:0] ad_c, ad2_c;
    logic [15:0]      n_c, dm1;
    logic [25:0]      nm_c;
    logic [64:0]      m2_sum;
    logic             var_inc;
    logic [41:0]      th_rnd;
    logic [34:0]      th_sum;

    always_comb begin
        case (r_sq_idx)
            2'd0:    sq_op = r_ax;
            2'd1:    sq_op = r_ay;
            default: sq_op = r_az;
        endcase
    end
    assign sq = sq_op * sq_op;

    assign up_c  = r_mag >= r_mean;
    assign ad_c  = up_c ? r_mag - r_mean : r_mean - r_mag;
    assign n_c   = r_count + 16'd1;
    assign dm1   = r_count - 16'd1;
    assign nm_c  = r_up ? {1'b0, r_mean} + div_q[25:0] : {1'b0, r_mean} - div_q[25:0];
    assign ad2_c = r_up ? r_mag - r_nm : r_nm - r_mag;
    assign m2_sum = {1'b0, r_m2} + 65'(r_prod);
    // Round the variance to nearest, halves up.
    assign var_inc = {1'b0, div_r} >= ({1'b0, dm1} - {1'b0, div_r});
    assign th_rnd  = 42'(r_thp) + 42'd128;
    assign th_sum  = 35'(th_rnd[41:8]) + 35'(r_mean);
    assign sqrt_rnd = {1'b0, sqrt_root} + 33'(sqrt_rem > {2'b00, sqrt_root});

    assign sqrt_start = (i_op == OP_SQRT_MAG) || (i_op == OP_VSQRT);
    assign sqrt_in    = (i_op == OP_SQRT_MAG) ? (64'(r_sum) << (2 * FRAC_BITS)) : r_var;
    assign div_start  = (i_op == OP_MDIV) || (i_op == OP_VDIV);
    assign div_in     = (i_op == OP_MDIV) ? 64'(ad_c) + 64'(n_c >> 1) : r_m2;
    assign div_d      = (i_op == OP_MDIV) ? n_c : dm1;

    rsqt_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_in),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root),
        .o_rem      (sqrt_rem)
    );

    rsqt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // Statistics state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_m2    <= '0;
            r_count <= '0;
            r_thr   <= '0;
            r_sigma <= SIGMA_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sigma <= i_cfg_data;
            end
            case (i_op)
                OP_CLR: begin
                    r_mean  <= '0;
                    r_m2    <= '0;
                    r_count <= '0;
                end
                OP_M2_UPD: begin
                    r_m2    <= m2_sum[64] ? '1 : m2_sum[63:0];
                    r_mean  <= r_nm;
                    r_count <= n_c;
                end
                OP_TH_ADD: begin
                    r_thr <= sat_val(64'(th_sum));
                end
                default: ;
            endcase
            if (i_op == OP_PUBLISH) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd    <= i_s_tuser[0];
                r_ax     <= abs16(i_s_tdata[15:0]);
                r_ay     <= abs16(i_s_tdata[31:16]);
                r_az     <= abs16(i_s_tdata[47:32]);
                r_sum    <= '0;
                r_sq_idx <= '0;
                r_mag    <= '0;
                r_sd     <= '0;
                r_upd    <= 1'b0;
                r_skip   <= 1'b0;
            end
            OP_CLR: r_stat <= ST_RESET;
            OP_SQ: begin
                r_sum    <= r_sum + sq;
                r_sq_idx <= r_sq_idx + 2'd1;
            end
            OP_MAG_TAKE: begin
                r_mag  <= sat_val(64'(sqrt_rnd));
                r_skip <= r_count >= 16'(MAX_SAMPLES);
                r_stat <= (r_count >= 16'(MAX_SAMPLES)) ? ST_IGNORED : ST_TAKEN;
            end
            OP_MDIV: begin
                r_up <= up_c;
                r_ad <= ad_c;
            end
            OP_MEAN:     r_nm   <= nm_c[VAL_W-1:0];
            OP_PROD:     r_prod <= r_ad * ad2_c;
            OP_VAR_TAKE: r_var  <= div_q + 64'(var_inc);
            OP_SD_TAKE:  r_sd   <= sat_val(64'(sqrt_rnd));
            OP_TH_MUL:   r_thp  <= r_sd * r_sigma;
            OP_TH_ADD:   r_upd  <= 1'b1;
            OP_PUBLISH: begin
                r_o_tdata <= {3'b000, r_upd, r_count, r_thr, r_sd, r_mean, r_mag};
                r_o_tuser <= r_stat;
            end
            default: ;
        endcase
    end

    assign o_st.sqrt_done = sqrt_done;
    assign o_st.div_done  = div_done;
    assign o_st.is_reset  = r_cmd;
    assign o_st.sq_last   = r_sq_idx == 2'd2;
    assign o_st.skip      = r_skip;
    assign o_st.cnt_lt2   = r_count < 16'd2;
    assign o_st.out_busy  = r_ov && !i_m_tready;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_o_tdata;
    assign o_m_tuser  = r_o_tuser;
endmodule

// File: design/rsqt_ctrl.sv
// Controller state machine that sequences the datapath for each item.
`include "running_stats_quake_threshold_macros.svh"
module rsqt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  rsqt_pkg::t_dp_status i_st,
    output rsqt_pkg::t_dp_op     o_op
);
    import rsqt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SQ     = 4'd2;
    localparam logic [3:0] S_MAGS   = 4'd3;
    localparam logic [3:0] S_MAGW   = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_MDIVW  = 4'd6;
    localparam logic [3:0] S_PROD   = 4'd7;
    localparam logic [3:0] S_M2     = 4'd8;
    localparam logic [3:0] S_CHK2   = 4'd9;
    localparam logic [3:0] S_VDIVW  = 4'd10;
    localparam logic [3:0] S_VSQ    = 4'd11;
    localparam logic [3:0] S_VSQW   = 4'd12;
    localparam logic [3:0] S_THM    = 4'd13;
    localparam logic [3:0] S_THA    = 4'd14;
    localparam logic [3:0] S_PUB    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.is_reset) begin
                    o_op    = OP_CLR;
                    n_state = S_PUB;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_op = OP_SQ;
                if (i_st.sq_last) n_state = S_MAGS;
            end
            S_MAGS: begin
                o_op    = OP_SQRT_MAG;
                n_state = S_MAGW;
            end
            S_MAGW: begin
                if (i_st.sqrt_done) begin
                    o_op    = OP_MAG_TAKE;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // A full period still reports its standard deviation.
                if (i_st.skip) begin
                    o_op    = OP_VDIV;
                    n_state = S_VDIVW;
                end else begin
                    o_op    = OP_MDIV;
                    n_state = S_MDIVW;
                end
            end
            S_MDIVW: begin
                if (i_st.div_done) begin
                    o_op    = OP_MEAN;
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                o_op    = OP_PROD;
                n_state = S_M2;
            end
            S_M2: begin
                o_op    = OP_M2_UPD;
                n_state = S_CHK2;
            end
            S_CHK2: begin
                if (i_st.cnt_lt2) begin
                    n_state = S_PUB;
                end else begin
                    o_op    = OP_VDIV;
                    n_state = S_VDIVW;
                end
            end
            S_VDIVW: begin
                if (i_st.div_done) begin
                    o_op    = OP_VAR_TAKE;
                    n_state = S_VSQ;
                end
            end
            S_VSQ: begin
                o_op    = OP_VSQRT;
                n_state = S_VSQW;
            end
            S_VSQW: begin
                if (i_st.sqrt_done) begin
                    o_op    = OP_SD_TAKE;
                    n_state = i_st.skip ? S_PUB : S_THM;
                end
            end
            S_THM: begin
                o_op    = OP_TH_MUL;
                n_state = S_THA;
            end
            S_THA: begin
                o_op    = OP_TH_ADD;
                n_state = S_PUB;
            end
            S_PUB: begin
                if (!i_st.out_busy) begin
                    o_op    = OP_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RSQT_ASSERT_NXT(a_accept_decode, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_DECODE)
    `RSQT_ASSERT_IMP(a_pub_free, i_clk, i_rst_n, o_op == OP_PUBLISH, !i_st.out_busy)
    `RSQT_ASSERT_IMP(a_sqrt_wait, i_clk, i_rst_n, i_st.sqrt_done, r_state == S_MAGW || r_state == S_VSQW)
    `RSQT_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, i_st.div_done, r_state == S_MDIVW || r_state == S_VDIVW)
endmodule

// File: design/running_stats_quake_threshold.sv
// Top level of the running statistics and detection threshold block.
//
//  channel  direction  signals                      contents
//  s        in         i_s_tvalid/o_s_tready        acceleration sample or period reset
//  m        out        o_m_tvalid/i_m_tready        magnitude, statistics, threshold
//  cfg      in         i_cfg_valid/o_cfg_ready      sigma multiplier, Q8.8
//
// A sample item runs three squaring steps and up to two 32-step square roots and
// two 64-step divisions on the shared bit-serial units. A period reset item goes
// from decode straight to publishing. One item is in work at a time.
// The output register lets the next item enter while a result waits.
// Reset is synchronous and active low and clears the statistics and the threshold.
module running_stats_quake_threshold #(
    parameter int MAX_SAMPLES = rsqt_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = rsqt_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // accel_x, accel_y, accel_z
    input  logic [0:0]   i_s_tuser,   // command
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [119:0] o_m_tdata,   // magnitude, mean_value, std_deviation,
                                      // quake_threshold, sample_total, threshold_updated
    output logic [1:0]   o_m_tuser,   // status
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);
    import rsqt_pkg::*;

    t_dp_op     op;
    t_dp_status st;

    assign o_cfg_ready = 1'b1;

    rsqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_op       (op)
    );

    rsqt_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_st        (st),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );
endmodule

// File: test/running_stats_quake_threshold_tb.sv
// Self-checking testbench for the running statistics and quake threshold block.
module running_stats_quake_threshold_tb;
    import rsqt_pkg::*;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [63:0] MAG_LIMIT = 64'h1FFFFFF;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic        cmd;
        logic [15:0] ax, ay, az;
    } t_accel_item;

    typedef struct {
        logic [24:0] mag, mean, sd, thr;
        logic [15:0] total;
        logic        upd;
        logic [1:0]  status;
    } t_stats_result;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata = '0;
    logic [0:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [119:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data = '0;

    running_stats_quake_threshold dut (.*);

    t_accel_item   pending_items[$];
    t_stats_result expected_stats[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    bit            hold_sender = 0;
    bit            stimulus_done = 0;

    // Shadow state of the block.
    logic [15:0] sigma_mult;
    logic [63:0] mean_acc, m2_acc, count_acc, thresh_acc;

    initial forever #5 i_clk = ~i_clk;

    function automatic logic [63:0] sqrt_rounded(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic logic [63:0] clip25(logic [63:0] v);
        return (v > MAG_LIMIT) ? MAG_LIMIT : v;
    endfunction

    function automatic logic [63:0] abs16(logic [15:0] v);
        return v[15] ? 64'h10000 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] period_stddev();
        logic [63:0] d, q, r;
        if (count_acc < 64'd2) return 64'd0;
        d = count_acc - 64'd1;
        q = m2_acc / d;
        r = m2_acc % d;
        if (r >= d - r) q++;
        return clip25(sqrt_rounded(q));
    endfunction

    function automatic t_stats_result predict_stats(t_accel_item it);
        t_stats_result res;
        logic [63:0] mag, n, ad, q, nm, ad2, prod, s;
        bit up;
        res.mag = '0; res.sd = '0; res.upd = 1'b0;
        if (it.cmd == CMD_CLEAR) begin
            mean_acc = 0; m2_acc = 0; count_acc = 0;
            res.status = ST_RESET;
        end else begin
            mag = abs16(it.ax) * abs16(it.ax) + abs16(it.ay) * abs16(it.ay)
                + abs16(it.az) * abs16(it.az);
            mag = clip25(sqrt_rounded(mag << 16));
            res.mag = mag[24:0];
            if (count_acc >= 64'(MAX_SAMPLES_DEF)) begin
                res.status = ST_IGNORED;
            end else begin
                n = count_acc + 64'd1;
                up = mag >= mean_acc;
                ad = up ? mag - mean_acc : mean_acc - mag;
                q = (ad + n / 2) / n;
                nm = up ? mean_acc + q : mean_acc - q;
                ad2 = up ? mag - nm : nm - mag;
                prod = ad * ad2;
                m2_acc = (m2_acc > ~prod) ? '1 : m2_acc + prod;
                mean_acc = clip25(nm);
                count_acc = n;
                if (n > 64'd1) begin
                    s = period_stddev();
                    thresh_acc = clip25(mean_acc + ((s * 64'(sigma_mult) + 64'd128) >> 8));
                    res.upd = 1'b1;
                end
                res.status = ST_TAKEN;
            end
            s = period_stddev();
            res.sd = s[24:0];
        end
        res.mean = mean_acc[24:0];
        res.thr = thresh_acc[24:0];
        res.total = count_acc[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: predicts at acceptance so expectations stay in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_stats.push_back(predict_stats(pending_items.pop_front()));
                send_gap <= $urandom_range(0, 4);
                i_s_tvalid <= 0;
            end else if (!i_s_tvalid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() > 0 && !hold_sender) begin
                    i_s_tvalid <= 1;
                    i_s_tuser <= pending_items[0].cmd;
                    i_s_tdata <= {pending_items[0].az, pending_items[0].ay,
                                  pending_items[0].ax};
                end
            end
        end
    end

    // Monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_stats_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_stats.size() == 0) begin
                    report_mismatch("unexpected result", 64'd1, 64'd0);
                end else begin
                    want = expected_stats.pop_front();
                    if (o_m_tdata[24:0] !== want.mag)
                        report_mismatch("magnitude", 64'(o_m_tdata[24:0]), 64'(want.mag));
                    if (o_m_tdata[49:25] !== want.mean)
                        report_mismatch("mean_value", 64'(o_m_tdata[49:25]), 64'(want.mean));
                    if (o_m_tdata[74:50] !== want.sd)
                        report_mismatch("std_deviation", 64'(o_m_tdata[74:50]),
                                        64'(want.sd));
                    if (o_m_tdata[99:75] !== want.thr)
                        report_mismatch("quake_threshold", 64'(o_m_tdata[99:75]),
                                        64'(want.thr));
                    if (o_m_tdata[115:100] !== want.total)
                        report_mismatch("sample_total", 64'(o_m_tdata[115:100]),
                                        64'(want.total));
                    if (o_m_tdata[116] !== want.upd)
                        report_mismatch("threshold_updated", 64'(o_m_tdata[116]),
                                        64'(want.upd));
                    if (o_m_tuser !== want.status)
                        report_mismatch("status", 64'(o_m_tuser), 64'(want.status));
                end
                recv_gap <= $urandom_range(0, 4);
                i_m_tready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_tready <= 0;
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !stimulus_done) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_item(logic cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_accel_item it;
        it.cmd = cmd; it.ax = x; it.ay = y; it.az = z;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_accel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 400)) - 200);
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic drain();
        wait (pending_items.size() == 0 && !i_s_tvalid);
        wait (expected_stats.size() == 0);
        // Idle cycles separate the phases.
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_sigma(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sigma_mult = v;
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 29) == 0)
                add_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                add_item(CMD_ADD, rand_accel(), rand_accel(), rand_accel());
        end
    endtask

    initial begin
        sigma_mult = SIGMA_RESET;
        mean_acc = 0; m2_acc = 0; count_acc = 0; thresh_acc = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: zero, extremes, first sample, clear, single-axis values.
        add_item(CMD_ADD, 16'h0000, 16'h0000, 16'h0000);
        add_item(CMD_ADD, 16'h8000, 16'h8000, 16'h8000);
        add_item(CMD_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_item(CMD_ADD, 16'hFFFF, 16'h0001, 16'h0000);
        add_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(CMD_ADD, 16'h0003, 16'h0004, 16'h0000);
        add_item(CMD_ADD, 16'h8000, 16'h0000, 16'h0000);
        add_item(CMD_ADD, 16'h0000, 16'h7FFF, 16'h8000);
        add_item(CMD_ADD, 16'h5555, 16'hAAAA, 16'h0F0F);
        add_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        add_item(CMD_ADD, 16'h0100, 16'h0100, 16'h0100);
        add_item(CMD_ADD, 16'h0100, 16'h0100, 16'h0100);
        add_item(CMD_ADD, 16'hF000, 16'h0FFF, 16'h1234);
        // Reset value of the sigma multiplier is in use up to here.
        drain();

        write_sigma(16'hFFFF);
        add_item(CMD_ADD, 16'h7FFF, 16'h0000, 16'h0000);
        add_item(CMD_ADD, 16'h0000, 16'h0000, 16'h0001);
        add_item(CMD_ADD, 16'h8000, 16'h8000, 16'h7FFF);
        random_phase(100);
        drain();

        write_sigma(16'h0000);
        random_phase(100);
        // Sender holds off midway until every expected result has come.
        wait (pending_items.size() < 50);
        hold_sender = 1;
        wait (expected_stats.size() == 0 && !i_s_tvalid);
        @(posedge i_clk);
        hold_sender = 0;
        drain();

        write_sigma(16'($urandom));
        random_phase(100);
        drain();

        write_sigma(16'h0180);
        random_phase(100);
        drain();
        stimulus_done = 1;

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
